// ----- src/slcr_pkg.sv -----
// ----------------------------------------------------------------------------
// slcr_pkg
// Shared types, codes and CRC helpers for the sensor link CRC receiver.
// ----------------------------------------------------------------------------
package slcr_pkg;

    localparam logic [7:0] POLY       = 8'hD4;
    localparam logic [7:0] CLASS_MASK = 8'hE0;
    localparam logic [7:0] CLASS_LOG  = 8'h20;
    localparam logic [7:0] CLASS_ACK  = 8'h40;
    localparam logic [7:0] CLASS_RPT  = 8'h60;

    typedef enum logic [1:0] {
        STK_NONE,
        STK_PUSH,
        STK_POP,
        STK_REPLACE
    } t_stack_op;

    typedef struct packed {
        t_stack_op  op;
        logic [7:0] data;
    } t_stack_cmd;

    function automatic logic [7:0] crc_step(input logic [7:0] c);
        logic [7:0] t;
        t = c[7] ? (c ^ POLY) : c;
        return {t[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] crc3(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int i = 0; i < 3; i++) begin
            c = crc_step(c);
        end
        return c >> 3;
    endfunction

    function automatic logic [7:0] coded(input logic [7:0] v);
        return crc3(v) | (v & CLASS_MASK);
    endfunction

    // Seed with the top byte, shift the command in MSB first, then three zeros.
    function automatic logic crc11_pass(input logic [7:0] cmd, input logic [7:0] top);
        logic [7:0] c;
        logic [7:0] p;
        c = top;
        p = cmd;
        for (int i = 0; i < 11; i++) begin
            c    = crc_step(c);
            c[0] = p[7];
            p    = {p[6:0], 1'b0};
        end
        return (c[7:3] == 5'd0);
    endfunction

endpackage

// ----- src/slcr_stack.sv -----
// ----------------------------------------------------------------------------
// slcr_stack
// Byte stack with the top two entries cached in registers and the rest in a
// memory with registered read data.
// ----------------------------------------------------------------------------
module slcr_stack #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  slcr_pkg::t_stack_cmd i_cmd,
    output logic [7:0]          o_top
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_mem_q;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_top, n_top;
    logic [7:0]    r_below, n_below;
    logic          r_below_sel, n_below_sel;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [CW-1:0] w_cm1, w_cm3;
    logic [7:0]    w_below;
    logic          w_empty, w_full;

    // The entry below the top comes from the memory right after a pop.
    assign w_below = r_below_sel ? r_mem_q : r_below;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_cm1   = r_count - CW'(1);
    assign w_cm3   = r_count - CW'(3);
    assign w_raddr = w_cm3[AW-1:0];
    assign o_top   = w_empty ? 8'h00 : r_top;

    always_comb begin
        n_count     = r_count;
        n_top       = r_top;
        n_below     = r_below;
        n_below_sel = r_below_sel;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = w_cm1[AW-1:0];
        if (i_en) begin
            n_below     = w_below;
            n_below_sel = 1'b0;
            case (i_cmd.op)
                slcr_pkg::STK_PUSH: begin
                    w_we  = 1'b1;
                    n_top = i_cmd.data;
                    if (w_full) begin
                        // overwrite the top, depth unchanged
                        w_waddr = AW'(DEPTH - 1);
                    end else begin
                        w_waddr = r_count[AW-1:0];
                        n_below = r_top;
                        n_count = r_count + CW'(1);
                    end
                end
                slcr_pkg::STK_POP: begin
                    if (!w_empty) begin
                        n_count     = w_cm1;
                        n_top       = w_below;
                        n_below_sel = 1'b1;
                        w_re        = (r_count >= CW'(3));
                    end
                end
                slcr_pkg::STK_REPLACE: begin
                    if (!w_empty) begin
                        w_we  = 1'b1;
                        n_top = i_cmd.data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_cmd.data;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_below_sel <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_below_sel <= n_below_sel;
        end
        r_top   <= n_top;
        r_below <= n_below;
    end

endmodule

// ----- src/sensor_link_crc_receiver.sv -----
// ----------------------------------------------------------------------------
// sensor_link_crc_receiver
// Checks sensor link bytes, keeps a byte stack and writes logged bytes out.
// ----------------------------------------------------------------------------
// Takes one received byte per clock unless stalled and returns one result per
// byte, passed through the input register and then the result register. Data
// bytes are pushed on the stack; command bytes are checked with the 11-bit CRC
// against a data byte on the stack top, else with the 3-bit CRC, and may pop,
// log, acknowledge or request a repeat. The stack top and the entry below it
// sit in registers, the deeper entries in a single-port memory with registered
// read, so a pop reads the refill in the same cycle; the next byte may follow.
// Stalls on the result side hold the input side through the input register.
module sensor_link_crc_receiver #(
    parameter int STACK_DEPTH = 64,
    parameter int LOG_DEPTH   = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_byte,
    output logic        o_log_write,
    output logic [10:0] o_log_addr,
    output logic [7:0]  o_log_data,
    output logic        o_log_full
);

    localparam int LPW = $clog2(LOG_DEPTH + 1);

    logic           r_in_valid;
    logic [7:0]     r_rx;
    logic           r_out_valid;
    logic           r_reply_valid, n_reply_valid;
    logic [7:0]     r_reply_byte, n_reply_byte;
    logic           r_log_write, n_log_write;
    logic [10:0]    r_log_addr, n_log_addr;
    logic [7:0]     r_log_data, n_log_data;
    logic           r_log_full, n_log_full;
    logic [LPW-1:0] r_log_ptr, n_log_ptr;

    logic                 w_adv;
    logic [7:0]           w_top;
    logic [7:0]           w_cls;
    logic [LPW+10:0]      w_ptr_ext;
    slcr_pkg::t_stack_cmd w_cmd;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_cls   = r_rx & slcr_pkg::CLASS_MASK;
    assign w_ptr_ext = {11'd0, r_log_ptr};

    slcr_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cmd   (w_cmd),
        .o_top   (w_top)
    );

    always_comb begin
        w_cmd.op      = slcr_pkg::STK_NONE;
        w_cmd.data    = r_rx;
        n_reply_valid = 1'b0;
        n_reply_byte  = 8'h00;
        n_log_write   = 1'b0;
        n_log_addr    = 11'd0;
        n_log_data    = 8'h00;
        n_log_full    = 1'b0;
        n_log_ptr     = r_log_ptr;
        if (r_rx[7]) begin
            w_cmd.op = slcr_pkg::STK_PUSH;
        end else if (w_top[7]) begin
            if (slcr_pkg::crc11_pass(r_rx, w_top)) begin
                if (w_cls == slcr_pkg::CLASS_LOG) begin
                    if (r_log_ptr < LPW'(LOG_DEPTH)) begin
                        n_log_write = 1'b1;
                        n_log_addr  = w_ptr_ext[10:0];
                        n_log_data  = w_top;
                        n_log_ptr   = r_log_ptr + LPW'(1);
                    end else begin
                        n_log_full = 1'b1;
                    end
                    // pop the logged byte and push the ack marker
                    w_cmd.op      = slcr_pkg::STK_REPLACE;
                    w_cmd.data    = slcr_pkg::CLASS_ACK;
                    n_reply_valid = 1'b1;
                    n_reply_byte  = slcr_pkg::coded(slcr_pkg::CLASS_ACK);
                end
            end else begin
                w_cmd.op      = slcr_pkg::STK_POP;
                n_reply_valid = 1'b1;
                n_reply_byte  = slcr_pkg::coded(slcr_pkg::CLASS_RPT);
            end
        end else if (slcr_pkg::crc3(r_rx) == 8'h00) begin
            if (w_cls == slcr_pkg::CLASS_ACK) begin
                w_cmd.op = slcr_pkg::STK_POP;
            end else if (w_cls == slcr_pkg::CLASS_RPT && w_top != 8'h00) begin
                n_reply_valid = 1'b1;
                n_reply_byte  = w_top;
            end
        end else begin
            n_reply_valid = 1'b1;
            n_reply_byte  = slcr_pkg::coded(slcr_pkg::CLASS_RPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_log_ptr   <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_log_ptr   <= n_log_ptr;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (!o_stall && i_valid) begin
            r_rx <= i_rx_byte;
        end
        if (w_adv) begin
            r_reply_valid <= n_reply_valid;
            r_reply_byte  <= n_reply_byte;
            r_log_write   <= n_log_write;
            r_log_addr    <= n_log_addr;
            r_log_data    <= n_log_data;
            r_log_full    <= n_log_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_reply_valid = r_reply_valid;
    assign o_reply_byte  = r_reply_byte;
    assign o_log_write   = r_log_write;
    assign o_log_addr    = r_log_addr;
    assign o_log_data    = r_log_data;
    assign o_log_full    = r_log_full;

endmodule

// ----- src/slcr_checker.sv -----
// ----------------------------------------------------------------------------
// slcr_checker
// Port-level checks for the sensor link CRC receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_rx_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_reply_valid,
    input logic [7:0]  o_reply_byte,
    input logic        o_log_write,
    input logic [10:0] o_log_addr,
    input logic [7:0]  o_log_data,
    input logic        o_log_full
);

    // Hold a stalled input transaction.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_rx_byte))
        else $error("stalled input transaction changed");

    // Hold a stalled result transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reply_byte) && $stable(o_log_data))
        else $error("stalled result transaction changed");

    // A log write and a dropped entry never come together.
    a_log_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_log_write && o_log_full))
        else $error("log write and log full in one transaction");

    // Every logged byte is data and is answered with the coded ack.
    a_log_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_log_write || o_log_full) |->
            o_reply_valid && o_reply_byte == slcr_pkg::coded(slcr_pkg::CLASS_ACK)
            && (o_log_full || o_log_data[7]))
        else $error("log transaction without ack or with non-data byte");

    // Silent fields stay zero.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reply_valid || o_reply_byte == 8'h00)
            && (o_log_write || (o_log_addr == 11'd0 && o_log_data == 8'h00)))
        else $error("inactive result field not zero");

endmodule

bind sensor_link_crc_receiver slcr_checker u_slcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_rx_byte     (i_rx_byte),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_reply_valid (o_reply_valid),
    .o_reply_byte  (o_reply_byte),
    .o_log_write   (o_log_write),
    .o_log_addr    (o_log_addr),
    .o_log_data    (o_log_data),
    .o_log_full    (o_log_full)
);
